// ===== hdl/stack_cpu_execute_top_assert.svh =====
// Assertion macros for the stack CPU execute block.
// Used by the port checker; needs nothing else.
`ifndef STACK_CPU_EXECUTE_TOP_ASSERT_SVH
`define STACK_CPU_EXECUTE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define SCE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define SCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sce_pkg.sv =====
// Shared types and constants of the stack CPU execute block.
// No dependencies.
package sce_pkg;

    localparam int WORD_W          = 16;
    localparam int ENTRY_W         = 13;
    localparam int STACK_DEPTH_DEF = 32;

    typedef logic [WORD_W-1:0] t_word;

    // instruction class, bits 14..13 when bit 15 is clear
    localparam logic [1:0] OP_JUMP  = 2'b00;
    localparam logic [1:0] OP_CJUMP = 2'b01;
    localparam logic [1:0] OP_CALL  = 2'b10;
    localparam logic [1:0] OP_ALU   = 2'b11;

    // stack pointer delta codes
    localparam logic [1:0] DELTA_NONE  = 2'b00;
    localparam logic [1:0] DELTA_UP    = 2'b01;
    localparam logic [1:0] DELTA_DOWN2 = 2'b10;
    localparam logic [1:0] DELTA_DOWN1 = 2'b11;

    // ALU function codes
    localparam logic [3:0] ALU_T    = 4'd0;
    localparam logic [3:0] ALU_N    = 4'd1;
    localparam logic [3:0] ALU_ADD  = 4'd2;
    localparam logic [3:0] ALU_AND  = 4'd3;
    localparam logic [3:0] ALU_OR   = 4'd4;
    localparam logic [3:0] ALU_XOR  = 4'd5;
    localparam logic [3:0] ALU_INV  = 4'd6;
    localparam logic [3:0] ALU_EQ   = 4'd7;
    localparam logic [3:0] ALU_SLT  = 4'd8;
    localparam logic [3:0] ALU_SHR  = 4'd9;
    localparam logic [3:0] ALU_DEC  = 4'd10;
    localparam logic [3:0] ALU_R    = 4'd11;
    localparam logic [3:0] ALU_MEM  = 4'd12;
    localparam logic [3:0] ALU_MUL  = 4'd13;
    localparam logic [3:0] ALU_SWAP = 4'd14;
    localparam logic [3:0] ALU_ULT  = 4'd15;

endpackage

// ===== hdl/sce_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

// ===== hdl/sce_stack.sv =====
// One stack store: a RAM plus a bypass for a write that hits the entry being read.
// Depends on sce_pkg and sce_ram.
module sce_stack
    import sce_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_word                    i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_word                    o_rd_data
);

    t_word ram_q;
    logic  r_fwd_hit;
    t_word r_fwd_data;

    sce_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // RAM returns old data on a same-address write; take the new word instead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
        r_fwd_data <= i_wr_data;
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : ram_q;

endmodule

// ===== hdl/sce_alu.sv =====
// The 16-function ALU of the stack CPU.
// Depends on sce_pkg.
module sce_alu
    import sce_pkg::*;
(
    input  logic [3:0] i_func,
    input  t_word      i_t,
    input  t_word      i_n,
    input  t_word      i_r,
    input  t_word      i_mem,
    output t_word      o_result
);

    // only the low word of the product is kept
    t_word prod;

    assign prod = i_n * i_t;

    always_comb begin
        case (i_func)
            ALU_T:    o_result = i_t;
            ALU_N:    o_result = i_n;
            ALU_ADD:  o_result = i_t + i_n;
            ALU_AND:  o_result = i_t & i_n;
            ALU_OR:   o_result = i_t | i_n;
            ALU_XOR:  o_result = i_t ^ i_n;
            ALU_INV:  o_result = ~i_t;
            ALU_EQ:   o_result = (i_t == i_n) ? '1 : '0;
            ALU_SLT:  o_result = ($signed(i_n) < $signed(i_t)) ? '1 : '0;
            ALU_SHR:  o_result = (i_t[WORD_W-1:4] != '0) ? '0 : (i_n >> i_t[3:0]);
            ALU_DEC:  o_result = i_t - t_word'(1);
            ALU_R:    o_result = i_r;
            ALU_MEM:  o_result = i_mem;
            ALU_MUL:  o_result = prod;
            ALU_SWAP: o_result = {i_t[7:0], i_t[15:8]};
            ALU_ULT:  o_result = (i_n < i_t) ? '1 : '0;
            default:  o_result = i_t;
        endcase
    end

endmodule

// ===== hdl/stack_cpu_execute_top.sv =====
// Stack CPU execute block: top level with state, decode and output register.
// Depends on sce_pkg, sce_stack (data and return stores) and sce_alu.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall) carries one instruction item: restart flag,
//   instruction word fetched at the last o_fetch_address, and the memory word at the
//   address given by the last o_top_value. The item is taken at an edge with valid high
//   and stall low.
// - Output channel (o_out_valid / i_out_stall) returns one result item per instruction:
//   next fetch address, new top of stack, store strobe/address/data, core-reset flag.
// - Config channel (i_cfg_valid / o_cfg_ready) writes the 13-bit entry word address;
//   write it only while the block is idle. Ready is high whenever out of reset.
// - Latency: the result of an item is valid the cycle after it is accepted.
// - Throughput: one instruction per clock unless stalled. The stack read loop sets this:
//   each item's next-entry address goes to both stack RAMs at the accept edge, and the
//   registered read data (with same-entry write bypass) is ready for the next item.
// - Receiver stall: the result stays in the output register and input stall is raised;
//   while the output register is not stalled, a new item is taken every cycle.
// - Reset (i_rst_n low, synchronous): pointers, top, program counter cleared, entry
//   address cleared, entry call pending; stack RAM contents are not cleared and no
//   clearing pass is run. Input stall is high during reset.
module stack_cpu_execute_top
    import sce_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_restart,
    input  t_word              i_instruction,
    input  t_word              i_read_data,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_word              o_fetch_address,
    output t_word              o_top_value,
    output logic               o_write_enable,
    output t_word              o_write_address,
    output t_word              o_write_data,
    output logic               o_was_reset,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ENTRY_W-1:0] i_cfg_entry_word_address
);

    localparam int PW = $clog2(STACK_DEPTH);
    localparam logic [PW:0] DEPTH_V = (PW+1)'(STACK_DEPTH);

    // wrap a stack pointer by a delta code, modulo the stack depth
    function automatic logic [PW-1:0] ptr_step(input logic [PW-1:0] p, input logic [1:0] code);
        logic [PW:0] pe;
        logic [PW:0] res;
        pe = {1'b0, p};
        case (code)
            DELTA_UP:    res = (pe + 1'b1 == DEPTH_V) ? '0 : pe + 1'b1;
            DELTA_DOWN2: res = (pe >= (PW+1)'(2)) ? pe - (PW+1)'(2) : pe + DEPTH_V - (PW+1)'(2);
            DELTA_DOWN1: res = (pe == '0) ? DEPTH_V - 1'b1 : pe - 1'b1;
            default:     res = pe;
        endcase
        return res[PW-1:0];
    endfunction

    // architectural state
    t_word               r_top, n_top;
    logic [PW-1:0]       r_dp, n_dp;
    logic [PW-1:0]       r_rp, n_rp;
    t_word               r_pc, n_pc;
    logic                r_start_pending, n_start_pending;
    logic [ENTRY_W-1:0]  r_entry;

    // output register
    logic                r_out_valid;
    t_word               r_fetch_address;
    t_word               r_top_value;
    logic                r_write_enable;
    t_word               r_write_address;
    t_word               r_write_data;
    logic                r_was_reset;

    logic                accept;
    logic                out_free;

    // state as seen by this item, after an optional restart
    t_word               t0;
    logic [PW-1:0]       dp0;
    logic [PW-1:0]       rp0;
    t_word               pc0;
    logic                sp0;
    t_word               insn;
    t_word               pc_inc;

    // stack read data for the current pointers
    t_word               n_val;
    t_word               r_val;
    t_word               alu_res;

    // stack write ports
    logic                d_wr_en, r_wr_en;
    logic [PW-1:0]       d_wr_addr, r_wr_addr;
    t_word               d_wr_data, r_wr_data;
    logic [PW-1:0]       d_rd_addr, r_rd_addr;

    // item results
    logic                res_we;
    t_word               res_wa, res_wd;
    logic                res_reset;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !i_rst_n || !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = i_rst_n;

    // restart zeroes the state and sets the pending start before this item's work
    assign t0  = i_restart ? '0 : r_top;
    assign dp0 = i_restart ? '0 : r_dp;
    assign rp0 = i_restart ? '0 : r_rp;
    assign pc0 = i_restart ? '0 : r_pc;
    assign sp0 = i_restart ? 1'b1 : r_start_pending;

    // a pending start replaces the fetched word by a call to the entry address
    assign insn   = sp0 ? {1'b0, OP_CALL, r_entry} : i_instruction;
    assign pc_inc = pc0 + t_word'(1);

    sce_alu u_alu (
        .i_func   (insn[11:8]),
        .i_t      (t0),
        .i_n      (n_val),
        .i_r      (r_val),
        .i_mem    (i_read_data),
        .o_result (alu_res)
    );

    always_comb begin
        n_top           = t0;
        n_dp            = dp0;
        n_rp            = rp0;
        n_pc            = pc_inc;
        n_start_pending = 1'b0;
        d_wr_en         = 1'b0;
        d_wr_addr       = ptr_step(dp0, DELTA_UP);
        d_wr_data       = t0;
        r_wr_en         = 1'b0;
        r_wr_addr       = ptr_step(rp0, DELTA_UP);
        r_wr_data       = {pc_inc[WORD_W-2:0], 1'b0};
        res_we          = 1'b0;
        res_wa          = '0;
        res_wd          = '0;
        res_reset       = 1'b0;

        if (insn[15]) begin
            // literal push
            n_dp    = ptr_step(dp0, DELTA_UP);
            d_wr_en = 1'b1;
            n_top   = {1'b0, insn[14:0]};
        end else begin
            case (insn[14:13])
                OP_JUMP: begin
                    n_pc = {3'b000, insn[12:0]};
                end
                OP_CJUMP: begin
                    n_top = n_val;
                    n_dp  = ptr_step(dp0, DELTA_DOWN1);
                    if (t0 == '0) begin
                        n_pc = {3'b000, insn[12:0]};
                    end
                end
                OP_CALL: begin
                    n_rp    = ptr_step(rp0, DELTA_UP);
                    r_wr_en = 1'b1;
                    n_pc    = {3'b000, insn[12:0]};
                end
                default: begin
                    if (insn[12]) begin
                        n_pc = {1'b0, r_val[WORD_W-1:1]};
                    end
                    n_top     = alu_res;
                    n_dp      = ptr_step(dp0, insn[1:0]);
                    n_rp      = ptr_step(rp0, insn[3:2]);
                    d_wr_en   = insn[7];
                    d_wr_addr = n_dp;
                    r_wr_en   = insn[6];
                    r_wr_addr = n_rp;
                    r_wr_data = t0;
                    if (insn[5]) begin
                        res_we = 1'b1;
                        res_wa = t0;
                        res_wd = n_val;
                    end
                end
            endcase
        end

        // empty return stack: core reset, store contents kept
        if (n_rp == '0) begin
            n_top           = '0;
            n_dp            = '0;
            n_pc            = '0;
            n_start_pending = 1'b1;
            res_reset       = 1'b1;
        end

        // writes only for accepted items
        d_wr_en = d_wr_en && accept;
        r_wr_en = r_wr_en && accept;
    end

    // read the entries the next item will see
    assign d_rd_addr = accept ? n_dp : r_dp;
    assign r_rd_addr = accept ? n_rp : r_rp;

    sce_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_data_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (d_wr_en),
        .i_wr_addr (d_wr_addr),
        .i_wr_data (d_wr_data),
        .i_rd_addr (d_rd_addr),
        .o_rd_data (n_val)
    );

    sce_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_return_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (r_wr_en),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (r_wr_data),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (r_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top           <= '0;
            r_dp            <= '0;
            r_rp            <= '0;
            r_pc            <= '0;
            r_start_pending <= 1'b1;
            r_entry         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entry <= i_cfg_entry_word_address;
            end
            if (accept) begin
                r_top           <= n_top;
                r_dp            <= n_dp;
                r_rp            <= n_rp;
                r_pc            <= n_pc;
                r_start_pending <= n_start_pending;
                r_out_valid     <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fetch_address <= n_pc;
            r_top_value     <= n_top;
            r_write_enable  <= res_we;
            r_write_address <= res_wa;
            r_write_data    <= res_wd;
            r_was_reset     <= res_reset;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fetch_address = r_fetch_address;
    assign o_top_value     = r_top_value;
    assign o_write_enable  = r_write_enable;
    assign o_write_address = r_write_address;
    assign o_write_data    = r_write_data;
    assign o_was_reset     = r_was_reset;

endmodule

// ===== hdl/sce_checker.sv =====
// Port-level checker for the stack CPU execute block, bound to the top level.
// Depends on sce_pkg and stack_cpu_execute_top_assert.svh.
`include "stack_cpu_execute_top_assert.svh"

module sce_checker
    import sce_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  o_in_stall,
    input logic  i_restart,
    input logic  o_out_valid,
    input logic  i_out_stall,
    input t_word o_fetch_address,
    input t_word o_top_value,
    input logic  o_write_enable,
    input t_word o_write_address,
    input t_word o_write_data,
    input logic  o_was_reset
);

    `SCE_ASSERT_NOW(a_reset_zeroes, o_out_valid && o_was_reset,
        o_fetch_address == '0 && o_top_value == '0, "core reset result not zero")
    `SCE_ASSERT_NOW(a_no_store_zero, o_out_valid && !o_write_enable,
        o_write_address == '0 && o_write_data == '0, "store fields set without store")
    `SCE_ASSERT_NEXT(a_restart_call, i_in_valid && !o_in_stall && i_restart,
        o_out_valid && !o_was_reset && o_top_value == '0 && o_fetch_address[15:13] == 3'b000,
        "restart did not run entry call")
    `SCE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_fetch_address) && $stable(o_top_value),
        "stalled result changed")

endmodule

bind stack_cpu_execute_top sce_checker u_sce_checker (.*);
